// ===== rtl/core/ial_pkg.sv =====
// Package for the indexed array list: sizes, action and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package ial_pkg;

  localparam int DEPTH  = 64;
  localparam int VAL_W  = 64;
  localparam int ACT_W  = 3;
  localparam int IDX_W  = 7;
  localparam int ST_W   = 2;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;

  localparam logic [ACT_W-1:0] ACT_PUSH     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ERASE    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MODIFY   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RETRIEVE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic cap;
    logic ptr_init;
    logic rd;
    logic wr_shift;
    logic finish;
  } ial_cmd_t;

  typedef struct packed {
    logic ok;
    logic is_insert;
    logic is_erase;
    logic is_retrieve;
    logic shift_done;
    logic out_free;
  } ial_sts_t;

endpackage

// ===== rtl/core/ial_ctrl.sv =====
// Controller state machine of the indexed array list.
// Depends on ial_pkg for the command and status structs.
module ial_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ial_pkg::ial_sts_t sts,
  output ial_pkg::ial_cmd_t cmd
);
  import ial_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SH_RD,
    S_SH_WR,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.ptr_init = 1'b1;
        if (!sts.ok) begin
          state_nxt = S_FINISH;
        end else if (sts.is_insert || sts.is_erase) begin
          state_nxt = S_SH_RD;
        end else if (sts.is_retrieve) begin
          cmd.rd    = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SH_RD: begin
        if (sts.shift_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_SH_RD;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap, cmd.rd, cmd.wr_shift, cmd.finish}))
    else $error("controller issued conflicting commands");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> $past(cmd.rd))
    else $error("shift write without a preceding read");
`endif

endmodule

// ===== rtl/core/ial_dp.sv =====
// Datapath of the indexed array list: item registers, word store,
// shift pointer, length and the result register.
// Depends on ial_pkg for sizes, codes and the command and status structs.
module ial_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ial_pkg::ACT_W-1:0] in_action,
  input  logic [ial_pkg::IDX_W-1:0] in_index,
  input  logic [ial_pkg::VAL_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ial_pkg::VAL_W-1:0] out_read_value,
  output logic [ial_pkg::IDX_W-1:0] out_count,
  output logic                      out_is_empty,
  output logic [ial_pkg::ST_W-1:0]  out_status,
  input  ial_pkg::ial_cmd_t         cmd,
  output ial_pkg::ial_sts_t         sts
);
  import ial_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  logic [ACT_W-1:0] act_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic [CNT_W-1:0] ptr_r;
  logic [CNT_W-1:0] ptr_nxt;
  logic [VAL_W-1:0] rd_data_r;

  logic             out_valid_r;
  logic [VAL_W-1:0] out_read_value_r;
  logic [IDX_W-1:0] out_count_r;
  logic             out_is_empty_r;
  logic [ST_W-1:0]  out_status_r;

  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] fill_ext;
  logic [CMP_W-1:0] ptr_ext;
  logic [CMP_W-1:0] fill_nxt_ext;
  logic [ST_W-1:0]  st;
  logic             full;
  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic [CNT_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] rd_addr;

  assign idx_ext      = CMP_W'(idx_r);
  assign fill_ext     = CMP_W'(fill_r);
  assign ptr_ext      = CMP_W'(ptr_r);
  assign fill_nxt_ext = CMP_W'(fill_nxt);
  assign full         = (fill_ext == CMP_W'(DEPTH));

  always_comb begin
    st = ST_OK;
    unique case (act_r)
      ACT_PUSH: begin
        if (full) st = ST_FULL;
      end
      ACT_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else if (idx_ext > fill_ext) begin
          st = ST_RANGE;
        end
      end
      ACT_ERASE, ACT_MODIFY, ACT_RETRIEVE: begin
        if (idx_ext >= fill_ext) st = ST_RANGE;
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  assign sts.ok          = (st == ST_OK);
  assign sts.is_insert   = (act_r == ACT_INSERT);
  assign sts.is_erase    = (act_r == ACT_ERASE);
  assign sts.is_retrieve = (act_r == ACT_RETRIEVE);
  assign sts.shift_done  = (act_r == ACT_INSERT) ? (ptr_ext == idx_ext)
                                                 : (ptr_ext + CMP_W'(1) >= fill_ext);
  assign sts.out_free    = !out_valid_r || !out_stall;

  always_comb begin
    fill_nxt = fill_r;
    if (st == ST_OK) begin
      case (act_r)
        ACT_PUSH, ACT_INSERT: fill_nxt = fill_r + CNT_W'(1);
        ACT_ERASE:            fill_nxt = fill_r - CNT_W'(1);
        ACT_CLEAR:            fill_nxt = '0;
        default:              fill_nxt = fill_r;
      endcase
    end
  end

  always_comb begin
    if (act_r == ACT_INSERT) begin
      rd_ptr = ptr_r - CNT_W'(1);
    end else if (act_r == ACT_ERASE) begin
      rd_ptr = ptr_r + CNT_W'(1);
    end else begin
      rd_ptr = idx_ext[CNT_W-1:0];
    end
    rd_addr = rd_ptr[ADDR_W-1:0];
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_init) begin
      ptr_nxt = (act_r == ACT_INSERT) ? fill_r : idx_ext[CNT_W-1:0];
    end else if (cmd.wr_shift) begin
      ptr_nxt = (act_r == ACT_INSERT) ? ptr_r - CNT_W'(1) : ptr_r + CNT_W'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r[ADDR_W-1:0];
    wr_data = rd_data_r;
    if (cmd.wr_shift) begin
      wr_en = 1'b1;
    end else if (cmd.finish && (st == ST_OK)) begin
      wr_data = val_r;
      case (act_r)
        ACT_PUSH: begin
          wr_en   = 1'b1;
          wr_addr = fill_r[ADDR_W-1:0];
        end
        ACT_INSERT, ACT_MODIFY: begin
          wr_en   = 1'b1;
          wr_addr = idx_ext[ADDR_W-1:0];
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act_r <= in_action;
      idx_r <= in_index;
      val_r <= in_value;
    end
    ptr_r <= ptr_nxt;
    if (cmd.finish) begin
      out_read_value_r <= ((act_r == ACT_RETRIEVE) && (st == ST_OK)) ? rd_data_r : '0;
      out_count_r      <= fill_nxt_ext[IDX_W-1:0];
      out_is_empty_r   <= (fill_nxt == '0);
      out_status_r     <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_is_empty   = out_is_empty_r;
  assign out_status     = out_status_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_ext <= CMP_W'(DEPTH))
    else $error("length exceeds the store depth");
  a_reject_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && (st != ST_OK)) |=> $stable(fill_r))
    else $error("rejected operation changed the length");
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("result appeared without a finished operation");
  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> (ptr_ext < fill_ext + CMP_W'(1)))
    else $error("shift write beyond the list end");
`endif

endmodule

// ===== rtl/core/indexed_array_list.sv =====
// Top level of the indexed array list: joins controller and datapath.
// Depends on ial_pkg, ial_ctrl and ial_dp.
//
//   chan  dir  handshake            fields
//   in_   in   in_valid/in_stall    in_action, in_index, in_value
//   out_  out  out_valid/out_stall  out_read_value, out_count, out_is_empty, out_status
//
// Push, modify, retrieve, clear and rejected items go from idle through the
// execute and finish states to out_valid; insert and erase pass a read and
// a write state per entry moved (up to DEPTH-1), one read and one write of
// the single-port word store per move, then return to idle for the next item.
// Reset clears the length and the controller; the store itself is not cleared.
// While out_stall holds the result, the block takes one more item and waits
// with it until the result register is free.
module indexed_array_list (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ial_pkg::ACT_W-1:0] in_action,
  input  logic [ial_pkg::IDX_W-1:0] in_index,
  input  logic [ial_pkg::VAL_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ial_pkg::VAL_W-1:0] out_read_value,
  output logic [ial_pkg::IDX_W-1:0] out_count,
  output logic                      out_is_empty,
  output logic [ial_pkg::ST_W-1:0]  out_status
);
  import ial_pkg::*;

  ial_cmd_t cmd;
  ial_sts_t sts;

  ial_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ial_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty),
    .out_status     (out_status),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ===== tb/ial_checker.sv =====
// Checker for the indexed array list: watches both channels, keeps its own
// copy of the list, predicts every result and compares it field by field.
// Depends on ial_pkg.
module ial_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [ial_pkg::ACT_W-1:0] in_action,
  input  logic [ial_pkg::IDX_W-1:0] in_index,
  input  logic [ial_pkg::VAL_W-1:0] in_value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [ial_pkg::VAL_W-1:0] out_read_value,
  input  logic [ial_pkg::IDX_W-1:0] out_count,
  input  logic                      out_is_empty,
  input  logic [ial_pkg::ST_W-1:0]  out_status,
  output int                        fail_count,
  output int                        pending,
  output int                        results_seen,
  output int                        full_cases,
  output int                        range_cases,
  output int                        peak_len
);
  import ial_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [IDX_W-1:0] count;
    logic             is_empty;
    logic [ST_W-1:0]  status;
  } list_result_t;

  logic [VAL_W-1:0] entries [DEPTH];
  int               entry_count;
  list_result_t     due_results [$];

  function automatic list_result_t apply_list_op(logic [ACT_W-1:0] act,
                                                 logic [IDX_W-1:0] idx,
                                                 logic [VAL_W-1:0] val);
    list_result_t res;
    int pos;
    int k;
    res = '0;
    res.status = ST_OK;
    pos = int'(idx);
    case (act)
      ACT_PUSH: begin
        if (entry_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          entries[entry_count] = val;
          entry_count++;
        end
      end
      ACT_INSERT: begin
        if (entry_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (pos > entry_count) begin
          res.status = ST_RANGE;
        end else begin
          for (k = entry_count; k > pos; k--) entries[k] = entries[k-1];
          entries[pos] = val;
          entry_count++;
        end
      end
      ACT_ERASE: begin
        if (pos >= entry_count) begin
          res.status = ST_RANGE;
        end else begin
          for (k = pos; k + 1 < entry_count; k++) entries[k] = entries[k+1];
          entry_count--;
        end
      end
      ACT_MODIFY: begin
        if (pos >= entry_count) res.status = ST_RANGE;
        else entries[pos] = val;
      end
      ACT_RETRIEVE: begin
        if (pos >= entry_count) res.status = ST_RANGE;
        else res.read_value = entries[pos];
      end
      ACT_CLEAR: begin
        entry_count = 0;
      end
      default: begin
      end
    endcase
    res.count    = IDX_W'(entry_count);
    res.is_empty = (entry_count == 0);
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      entry_count  = 0;
      fail_count   = 0;
      results_seen = 0;
      full_cases   = 0;
      range_cases  = 0;
      peak_len     = 0;
      due_results.delete();
    end else begin
      // The result side is checked first, so that a result can never be
      // matched against an item taken at the same edge.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("result transfer with no result expected");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_read_value !== want.read_value) begin
            $error("out_read_value: expected %h, got %h", want.read_value, out_read_value);
            fail_count++;
          end
          if (out_count !== want.count) begin
            $error("out_count: expected %0d, got %0d", want.count, out_count);
            fail_count++;
          end
          if (out_is_empty !== want.is_empty) begin
            $error("out_is_empty: expected %0b, got %0b", want.is_empty, out_is_empty);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_list_op(in_action, in_index, in_value);
        if (want.status == ST_FULL) full_cases++;
        if (want.status == ST_RANGE) range_cases++;
        if (entry_count > peak_len) peak_len = entry_count;
        due_results.push_back(want);
      end
    end
    pending = due_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the indexed array list: makes clock, reset and the
// directed and random item stream, and drives the result stall pattern.
// Depends on ial_pkg, indexed_array_list and ial_checker.
module tb_top;
  import ial_pkg::*;

  localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES  = 400;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [ACT_W-1:0] in_action = '0;
  logic [IDX_W-1:0] in_index  = '0;
  logic [VAL_W-1:0] in_value  = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VAL_W-1:0] out_read_value;
  logic [IDX_W-1:0] out_count;
  logic             out_is_empty;
  logic [ST_W-1:0]  out_status;

  int fail_count;
  int pending;
  int results_seen;
  int full_cases;
  int range_cases;
  int peak_len;

  int list_len   = 0;
  int burst_left = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  indexed_array_list u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_index      (in_index),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_value(out_read_value),
    .out_count     (out_count),
    .out_is_empty  (out_is_empty),
    .out_status    (out_status)
  );

  ial_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_index      (in_index),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_value(out_read_value),
    .out_count     (out_count),
    .out_is_empty  (out_is_empty),
    .out_status    (out_status),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .full_cases    (full_cases),
    .range_cases   (range_cases),
    .peak_len      (peak_len)
  );

  // Only the list length is tracked here, to steer the indexes.
  task automatic offer(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] idx,
                       input logic [VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(8, 0);
      burst_left = $urandom_range(40, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_action <= act;
    in_index  <= idx;
    in_value  <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    case (act)
      ACT_PUSH:   if (list_len < DEPTH) list_len++;
      ACT_INSERT: if (list_len < DEPTH && int'(idx) <= list_len) list_len++;
      ACT_ERASE:  if (int'(idx) < list_len) list_len--;
      ACT_CLEAR:  list_len = 0;
      default: begin
      end
    endcase
  endtask

  function automatic logic [IDX_W-1:0] pick_index(bit for_insert);
    int hi;
    int roll;
    hi = for_insert ? list_len : list_len - 1;
    if (hi < 0) hi = 0;
    roll = $urandom_range(99);
    if (roll < 85) return IDX_W'($urandom_range(hi, 0));
    if (roll < 95) return IDX_W'($urandom_range(DEPTH, list_len));
    return IDX_W'($urandom_range(2**IDX_W - 1, 0));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    return {$urandom, $urandom};
  endfunction

  // Mode 0 grows the list toward full, mode 1 shrinks it, mode 2 mixes all.
  function automatic logic [ACT_W-1:0] pick_action(int mode);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      0: begin
        if (roll < 40) return ACT_PUSH;
        if (roll < 75) return ACT_INSERT;
        if (roll < 85) return ACT_RETRIEVE;
        if (roll < 95) return ACT_MODIFY;
        return ACT_ERASE;
      end
      1: begin
        if (roll < 45) return ACT_ERASE;
        if (roll < 65) return ACT_RETRIEVE;
        if (roll < 80) return ACT_MODIFY;
        if (roll < 90) return ACT_PUSH;
        return ACT_INSERT;
      end
      default: begin
        if (roll < 18) return ACT_PUSH;
        if (roll < 36) return ACT_INSERT;
        if (roll < 54) return ACT_ERASE;
        if (roll < 70) return ACT_MODIFY;
        if (roll < 88) return ACT_RETRIEVE;
        if (roll < 94) return ACT_CLEAR;
        if (roll < 97) return ACT_RSVD6;
        return ACT_RSVD7;
      end
    endcase
  endfunction

  initial begin : stimulus
    int done;
    int mode;
    int phase_left;
    int waited;
    logic [ACT_W-1:0] act;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: an empty list, edges of insert, reads across the list,
    // unused actions and a clear that leaves the old words behind.
    offer(ACT_RETRIEVE, 7'd0, '0);
    offer(ACT_ERASE, 7'd0, '0);
    offer(ACT_MODIFY, 7'd0, '1);
    offer(ACT_INSERT, 7'd1, 64'h1111_2222_3333_4444);
    offer(ACT_INSERT, 7'd0, '1);
    offer(ACT_PUSH, 7'd127, '0);
    offer(ACT_INSERT, 7'd2, 64'hA5A5_5A5A_F00D_CAFE);
    offer(ACT_INSERT, 7'd1, 64'h0123_4567_89AB_CDEF);
    offer(ACT_RETRIEVE, 7'd0, '0);
    offer(ACT_RETRIEVE, 7'd1, '0);
    offer(ACT_RETRIEVE, 7'd2, '0);
    offer(ACT_RETRIEVE, 7'd3, '0);
    offer(ACT_RETRIEVE, 7'd4, '0);
    offer(ACT_RETRIEVE, 7'd127, '0);
    offer(ACT_MODIFY, 7'd3, 64'hDEAD_BEEF_0BAD_F00D);
    offer(ACT_RETRIEVE, 7'd3, '0);
    offer(ACT_ERASE, 7'd0, '0);
    offer(ACT_ERASE, 7'd2, '0);
    offer(ACT_RETRIEVE, 7'd0, '0);
    offer(ACT_RSVD6, 7'd127, '1);
    offer(ACT_RSVD7, 7'd0, '1);
    offer(ACT_CLEAR, 7'd0, '0);
    offer(ACT_RETRIEVE, 7'd0, '0);
    offer(ACT_ERASE, 7'd0, '0);

    done = 0;
    phase_left = 0;
    mode = 0;
    while (done < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        mode = $urandom_range(2);
        phase_left = (mode == 0) ? $urandom_range(140, 70) : $urandom_range(80, 20);
      end
      phase_left--;
      act = pick_action(mode);
      offer(act, pick_index(act == ACT_INSERT), pick_value());
      if (act != ACT_RSVD6 && act != ACT_RSVD7) done++;
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);

    $display("Sent %0d items and checked %0d results; the list peaked at %0d entries,",
             items_sent, results_seen, peak_len);
    $display("with %0d full-store rejects and %0d out-of-range rejects.",
             full_cases, range_cases);
    if (fail_count == 0 && pending == 0) begin
      $display("indexed_array_list test passed");
    end else begin
      $display("indexed_array_list test failed");
    end
    $finish;
  end

  // The result side alternates free, light and heavy stall stretches, and
  // once holds off long enough for the block to back up its input.
  initial begin : receiver
    int mode;
    int stretch;
    bit held_off;
    held_off = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && results_seen >= 500) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(2);
      stretch = $urandom_range(60, 10);
      repeat (stretch) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(99) < 30);
          default: out_stall <= ($urandom_range(99) < 75);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("indexed_array_list test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ial_pkg.sv
rtl/core/ial_ctrl.sv
rtl/core/ial_dp.sv
rtl/core/indexed_array_list.sv
tb/ial_checker.sv
tb/tb_top.sv
